// ----- src/sha256_byte_stream_hasher_macros.svh -----
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SHB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SHB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/shb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package shb_pkg;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned TOTAL_W = 61;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] hash_t;

	// Job handed from the packer to the compression engine.
	typedef struct packed {
		word_t [15:0] blk;
		logic         fin;   // digest is emitted after this block
	} job_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_ROUND,
		ENG_ADD
	} eng_state_t;

	typedef enum logic [1:0] {
		PK_BYTES,
		PK_PAD,
		PK_LEN
	} pk_state_t;

	localparam hash_t INIT_HASH = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	localparam word_t [63:0] ROUND_K = '{
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LENGTH_POS = 6'd56;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ----- src/shb_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_in_if / shb_out_if
// Valid/ready channels for message bytes and digests.
// ----------------------------------------------------------------------------
interface shb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;
	logic       no_data;
	modport source (output valid, data_byte, is_last, no_data, input ready);
	modport sink (input valid, data_byte, is_last, no_data, output ready);
endinterface

interface shb_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_part_0;
	logic [63:0] digest_part_1;
	logic [63:0] digest_part_2;
	logic [63:0] digest_part_3;
	modport source (output valid, digest_part_0, digest_part_1, digest_part_2,
		digest_part_3, input ready);
	modport sink (input valid, digest_part_0, digest_part_1, digest_part_2,
		digest_part_3, output ready);
endinterface

// ----- src/shb_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_packer
// Front end: packs bytes into blocks, appends padding and bit length.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_macros.svh"
module shb_packer (
	input  logic          clk,
	input  logic          arst_n,
	shb_in_if.sink        in_ch,
	output shb_pkg::job_t job,
	output logic          job_valid,
	input  logic          job_ready
);
	import shb_pkg::*;

	pk_state_t            state_q, state_d;
	word_t [15:0]         blk_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [5:0]           pos_q;      // padding write position
	logic                 blk_full_q; // block waiting for the queue
	logic                 fin_q;
	logic                 second_q;   // second pad block in progress
	logic                 take;
	logic [5:0]           fill;
	logic [63:0]          bits;

	assign fill = total_q[5:0];
	assign bits = {total_q, 3'b000};

	assign in_ch.ready = (state_q == PK_BYTES) && !blk_full_q;
	assign take = in_ch.valid && in_ch.ready;
	assign job_valid = blk_full_q;
	assign job.blk = blk_q;
	assign job.fin = fin_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PK_BYTES: begin
				if (take && in_ch.is_last) begin
					state_d = PK_PAD;
				end
			end
			PK_PAD: begin
				if (!blk_full_q && pos_q == 6'd63) begin
					state_d = (fill >= LENGTH_POS && !second_q) ? PK_PAD : PK_LEN;
				end
			end
			PK_LEN: begin
				if (!blk_full_q) begin
					state_d = PK_BYTES;
				end
			end
			default: state_d = PK_BYTES;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PK_BYTES;
			total_q    <= '0;
			pos_q      <= '0;
			blk_full_q <= 1'b0;
			fin_q      <= 1'b0;
			second_q   <= 1'b0;
		end else begin
			if (blk_full_q && job_ready) begin
				blk_full_q <= 1'b0;
			end
			state_q <= state_d;
			unique case (state_q)
				PK_BYTES: begin
					if (take) begin
						if (!in_ch.no_data) begin
							total_q <= total_q + 1'b1;
							if (total_q[5:0] == 6'd63) begin
								blk_full_q <= 1'b1;
								fin_q      <= 1'b0;
							end
						end
						if (in_ch.is_last) begin
							pos_q <= in_ch.no_data ? total_q[5:0] : total_q[5:0] + 1'b1;
						end
					end
				end
				PK_PAD: begin
					if (!blk_full_q) begin
						pos_q <= pos_q + 1'b1;
						if (pos_q == 6'd63 && fill >= LENGTH_POS && !second_q) begin
							blk_full_q <= 1'b1;
							fin_q      <= 1'b0;
							second_q   <= 1'b1;
						end
					end
				end
				PK_LEN: begin
					if (!blk_full_q) begin
						blk_full_q <= 1'b1;
						fin_q      <= 1'b1;
						total_q    <= '0;
						second_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Block payload; a second pad block is all zeros ahead of the length.
	always_ff @(posedge clk) begin
		if (state_q == PK_BYTES && take && !in_ch.no_data) begin
			blk_q[4'(15 - total_q[5:2])][8*(3-total_q[1:0]) +: 8] <= in_ch.data_byte;
		end else if (state_q == PK_PAD && !blk_full_q) begin
			blk_q[4'(15 - pos_q[5:2])][8*(3-pos_q[1:0]) +: 8] <=
				(pos_q == fill && !second_q) ? PAD_BYTE : 8'h00;
		end else if (state_q == PK_LEN && !blk_full_q) begin
			blk_q[1] <= bits[63:32];
			blk_q[0] <= bits[31:0];
		end
	end

	`SHB_ASSERT_NXT(a_no_take_when_full, clk, arst_n, blk_full_q && !job_ready,
		blk_full_q, "pending block lost")
	`SHB_ASSERT_IMP(a_ready_only_bytes, clk, arst_n, in_ch.ready,
		state_q == PK_BYTES, "input ready outside byte phase")
	`SHB_ASSERT_NXT(a_len_sets_fin, clk, arst_n, state_q == PK_LEN && !blk_full_q,
		blk_full_q && fin_q, "length block not queued as final")
endmodule

// ----- src/shb_job_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_job_queue
// Two-entry queue of block jobs between packer and compression engine.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_macros.svh"
module shb_job_queue #(
	parameter int unsigned DEPTH = shb_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  shb_pkg::job_t wr_job,
	input  logic          wr_valid,
	output logic          wr_ready,
	output shb_pkg::job_t rd_job,
	output logic          rd_valid,
	input  logic          rd_ready
);
	import shb_pkg::*;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`SHB_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= (AW+1)'(DEPTH),
		"queue count overflow")
	`SHB_ASSERT_NXT(a_push_nonempty, clk, arst_n, push, rd_valid,
		"queue empty after push")
	`SHB_ASSERT_NXT(a_cnt_hold, clk, arst_n, !push && !pop, $stable(cnt_q),
		"queue count moved without traffic")
endmodule

// ----- src/shb_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_engine
// Back end: 64 rounds per block, one per cycle, then chaining add.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_macros.svh"
module shb_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  shb_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_ready,
	shb_out_if.source     out_ch
);
	import shb_pkg::*;

	eng_state_t   state_q, state_d;
	hash_t        chain_q, work_q;
	word_t [15:0] w_q;        // schedule ring, w_q[0] is current word
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic         out_valid_q;
	hash_t        dig_q;
	word_t        w15, w2, g0, g1, wnew, s1, ch, t1, s0, maj;
	logic         start;

	// a job is taken only when it will really start
	assign job_ready = state_q == ENG_IDLE && !(out_valid_q && !out_ch.ready);
	assign start = job_ready && job_valid;

	// job.blk[15] is the first word of the block
	assign w15 = w_q[1];
	assign w2 = w_q[14];
	assign g0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
	assign g1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
	assign wnew = w_q[0] + g0 + w_q[9] + g1;

	assign s1 = rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25);
	assign ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign t1 = work_q[7] + s1 + ch + ROUND_K[rnd_q] + w_q[0];
	assign s0 = rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^
		(work_q[1] & work_q[2]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE:  if (start) state_d = ENG_ROUND;
			ENG_ROUND: if (rnd_q == 6'd63) state_d = ENG_ADD;
			ENG_ADD:   state_d = ENG_IDLE;
			default:   state_d = ENG_IDLE;
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.digest_part_0 = {dig_q[0], dig_q[1]};
	assign out_ch.digest_part_1 = {dig_q[2], dig_q[3]};
	assign out_ch.digest_part_2 = {dig_q[4], dig_q[5]};
	assign out_ch.digest_part_3 = {dig_q[6], dig_q[7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_IDLE;
			rnd_q       <= '0;
			chain_q     <= INIT_HASH;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ENG_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (state_q == ENG_IDLE && state_d == ENG_ROUND) begin
				fin_q <= job.fin;
			end
			if (state_q == ENG_ADD) begin
				if (fin_q) begin
					chain_q     <= INIT_HASH;
					out_valid_q <= 1'b1;
				end else begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ENG_IDLE && state_d == ENG_ROUND) begin
			work_q <= chain_q;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= job.blk[15 - i];
			end
		end else if (state_q == ENG_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnew;
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + s0 + maj;
		end
		if (state_q == ENG_ADD && fin_q) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[i] <= chain_q[i] + work_q[i];
			end
		end
	end

	`SHB_ASSERT_IMP(a_rnd_zero_idle, clk, arst_n, state_q == ENG_IDLE, rnd_q == 6'd0,
		"round counter not zero between blocks")
	`SHB_ASSERT_NXT(a_add_after_63, clk, arst_n, state_q == ENG_ROUND && rnd_q == 6'd63,
		state_q == ENG_ADD, "missing chaining add")
	`SHB_ASSERT_IMP(a_no_overwrite, clk, arst_n, state_q == ENG_ADD && fin_q,
		!out_valid_q || out_ch.ready, "digest overwritten while stalled")
endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 of a byte stream, one byte per input beat, digest per message.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one message byte per beat; is_last marks the final beat,
//    no_data marks a beat without a byte (alone with is_last: empty message).
//  - out_ch gives one 256-bit digest beat per message, big-endian parts.
//  - Bytes are taken one per cycle into the packer block register; when 64
//    bytes are in, the block moves to a two-entry job queue; the packer
//    pauses for that handoff and while the queue is full.
//  - The engine runs one round per cycle: 1 load + 64 rounds + 1 add per
//    block; it takes a new block only once it is back in idle.
//  - After the last beat the packer writes padding byte by byte from the
//    fill level to the block end (and through a whole second pad block
//    when one is needed), then the length, and then the engine finishes.
//  - Reset clears all control state and loads the initial hash values; no
//    clearing pass is needed.
//  - When out_ch stalls the digest is held in its register; the engine does
//    not start the next block, and the packer keeps filling until the queue
//    fills.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_macros.svh"
module sha256_byte_stream_hasher #(
	parameter int unsigned QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	shb_in_if.sink    in_ch,
	shb_out_if.source out_ch
);
	import shb_pkg::*;

	job_t pk_job, q_job;
	logic pk_valid, pk_ready, q_valid, q_ready;

	shb_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.job      (pk_job),
		.job_valid(pk_valid),
		.job_ready(pk_ready)
	);

	shb_job_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_job  (pk_job),
		.wr_valid(pk_valid),
		.wr_ready(pk_ready),
		.rd_job  (q_job),
		.rd_valid(q_valid),
		.rd_ready(q_ready)
	);

	shb_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (q_job),
		.job_valid(q_valid),
		.job_ready(q_ready),
		.out_ch   (out_ch)
	);

	`SHB_ASSERT_NXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.digest_part_0), "digest dropped while stalled")
	`SHB_ASSERT_IMP(a_handoff, clk, arst_n, pk_valid && pk_ready, !$isunknown(pk_job.fin),
		"unknown job flag")
	`SHB_ASSERT_IMP(a_pop_valid, clk, arst_n, q_ready && q_valid, !$isunknown(q_job.fin),
		"unknown queue output")
endmodule
